[rtl/core/wsd_pkg.sv]
// WebSocket deframer package: phase and result kind codes, protocol
// constants and the command record passed from the parser to the output stage.
// No dependencies.
`timescale 1ns / 1ps

package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT0,
    PH_EXT1,
    PH_KEY,
    PH_DATA
  } phase_t;

  typedef enum logic [2:0] {
    K_TEXT,
    K_EMPTY,
    K_IGNORED,
    K_CLOSE,
    K_UNMASKED,
    K_LONG
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] key;
    logic       last;
  } cmd_t;

  localparam logic [3:0] OpText    = 4'h1;
  localparam logic [3:0] OpClose   = 4'h8;
  localparam logic [6:0] LenExt16  = 7'd126;
  localparam logic [6:0] LenLong   = 7'd127;
  localparam int         QueueDepth = 4;

endpackage

[rtl/core/wsd_if.sv]
// Valid/ready channel interfaces for received bytes and deframer results.
// Depends on nothing.
`timescale 1ns / 1ps

interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] payload_byte;
  logic       frame_last;

  modport source (output valid, output kind, output payload_byte, output frame_last,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte, input frame_last,
                  output ready);
endinterface

[rtl/core/wsd_front.sv]
// Frame parser: tracks header, extended length, mask key and payload phases
// and issues one command per result. Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  output logic          push,
  output wsd_pkg::cmd_t cmd
);

  wsd_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic [15:0] left_r, left_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  kidx_r, kidx_nxt;
  logic        halted_r, halted_nxt;

  logic [6:0] code;
  logic       data_last;
  logic       is_text;

  assign code      = rx_byte[6:0];
  assign data_last = (left_r == 16'd1);
  assign is_text   = (opcode_r == wsd_pkg::OpText);

  always_comb begin
    phase_nxt = phase_r;
    if (accept && !halted_r) begin
      case (phase_r)
        wsd_pkg::PH_HDR1: begin
          if (rx_byte[7] && code != wsd_pkg::LenLong) begin
            phase_nxt = (code == wsd_pkg::LenExt16) ? wsd_pkg::PH_EXT0 : wsd_pkg::PH_KEY;
          end
        end
        wsd_pkg::PH_EXT0: phase_nxt = wsd_pkg::PH_EXT1;
        wsd_pkg::PH_EXT1: phase_nxt = wsd_pkg::PH_KEY;
        wsd_pkg::PH_KEY: begin
          if (kidx_r == 2'd3) begin
            phase_nxt = (left_r == 16'd0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_DATA;
          end
        end
        wsd_pkg::PH_DATA: begin
          if (data_last) begin
            phase_nxt = wsd_pkg::PH_HDR0;
          end
        end
        default: phase_nxt = wsd_pkg::PH_HDR1;
      endcase
    end
  end

  always_comb begin
    opcode_nxt = opcode_r;
    left_nxt   = left_r;
    key_nxt    = key_r;
    kidx_nxt   = kidx_r;
    halted_nxt = halted_r;
    push       = 1'b0;
    cmd.kind   = wsd_pkg::K_IGNORED;
    cmd.data   = 8'h00;
    cmd.key    = 8'h00;
    cmd.last   = 1'b1;
    if (accept && !halted_r) begin
      case (phase_r)
        wsd_pkg::PH_HDR1: begin
          if (!rx_byte[7]) begin
            halted_nxt = 1'b1;
            push       = 1'b1;
            cmd.kind   = wsd_pkg::K_UNMASKED;
          end else if (code == wsd_pkg::LenLong) begin
            halted_nxt = 1'b1;
            push       = 1'b1;
            cmd.kind   = wsd_pkg::K_LONG;
          end else if (code != wsd_pkg::LenExt16) begin
            left_nxt = {9'd0, code};
            kidx_nxt = 2'd0;
          end
        end
        wsd_pkg::PH_EXT0: left_nxt = {rx_byte, 8'h00};
        wsd_pkg::PH_EXT1: begin
          left_nxt = {left_r[15:8], rx_byte};
          kidx_nxt = 2'd0;
        end
        wsd_pkg::PH_KEY: begin
          key_nxt = {key_r[23:0], rx_byte};
          if (kidx_r == 2'd3) begin
            kidx_nxt = 2'd0;
            if (left_r == 16'd0) begin
              push = 1'b1;
              if (opcode_r == wsd_pkg::OpClose) begin
                halted_nxt = 1'b1;
                cmd.kind   = wsd_pkg::K_CLOSE;
              end else if (is_text) begin
                cmd.kind = wsd_pkg::K_EMPTY;
              end
            end
          end else begin
            kidx_nxt = kidx_r + 2'd1;
          end
        end
        wsd_pkg::PH_DATA: begin
          kidx_nxt = data_last ? 2'd0 : kidx_r + 2'd1;
          left_nxt = left_r - 16'd1;
          if (is_text) begin
            push     = 1'b1;
            cmd.kind = wsd_pkg::K_TEXT;
            cmd.data = rx_byte;
            cmd.key  = key_r[{~kidx_r, 3'b000} +: 8];
            cmd.last = data_last;
          end else if (data_last) begin
            push = 1'b1;
            if (opcode_r == wsd_pkg::OpClose) begin
              halted_nxt = 1'b1;
              cmd.kind   = wsd_pkg::K_CLOSE;
            end
          end
        end
        default: opcode_nxt = rx_byte[3:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsd_pkg::PH_HDR0;
      opcode_r <= 4'd0;
      left_r   <= 16'd0;
      key_r    <= 32'd0;
      kidx_r   <= 2'd0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      left_r   <= left_nxt;
      key_r    <= key_nxt;
      kidx_r   <= kidx_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

[rtl/core/wsd_fifo.sv]
// Short command queue between the parser and the output stage.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_fifo #(
  parameter int Depth = wsd_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wsd_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output wsd_pkg::cmd_t dout,
  output logic          empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  wsd_pkg::cmd_t   mem [Depth];
  logic [PtrW-1:0] wptr_r, wptr_nxt;
  logic [PtrW-1:0] rptr_r, rptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full  = (count_r == DepthCnt);
  assign empty = (count_r == '0);
  assign dout  = mem[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == LastPtr) ? '0 : wptr_r + PtrW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == LastPtr) ? '0 : rptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) count_r <= DepthCnt)
    else $error("queue count out of range");
`endif

endmodule

[rtl/core/wsd_back.sv]
// Output stage: pops commands, unmasks text bytes and holds the result
// register on the output channel. Depends on wsd_pkg and wsd_if.
`timescale 1ns / 1ps

module wsd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          empty,
  input  wsd_pkg::cmd_t dout,
  output logic          pop,
  wsd_out_if.source     out_ch
);

  logic       valid_r, valid_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       load;

  assign load = !valid_r || out_ch.ready;
  assign pop  = load && !empty;

  always_comb begin
    valid_nxt = valid_r;
    kind_nxt  = kind_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = !empty;
      kind_nxt  = 3'(dout.kind);
      byte_nxt  = (dout.kind == wsd_pkg::K_TEXT) ? (dout.data ^ dout.key) : 8'h00;
      last_nxt  = dout.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.payload_byte = byte_r;
  assign out_ch.frame_last   = last_r;

endmodule

[rtl/core/websocket_frame_deframer_top.sv]
// WebSocket client frame deframer. Receives one byte per transaction on
// in_ch and returns unmasked text bytes and frame status on out_ch.
// in_ch carries rx_byte. in_ch.ready is high while the command queue has
// room; a transaction is taken every cycle while in_ch.ready is high.
// out_ch carries kind, payload_byte and frame_last. kind 0 is a text byte,
// 1 an empty text frame, 2 an ignored frame, 3 close, 4 an unmasked frame
// error, 5 a 64-bit length error. After close or an error all later bytes
// are accepted and dropped until reset.
// Path: a result passes from the parser into the queue, then from the queue
// into the output register; one item per cycle while out_ch.ready is high.
// When the receiver stalls, results wait in the QUEUE_DEPTH-entry queue and
// the output register; in_ch.ready drops only once the queue is full.
// Reset (rst_n low, synchronous) returns the parser to the first header byte,
// clears the halt, and empties the queue and output register.
// Depends on wsd_pkg, wsd_if, wsd_front, wsd_fifo, wsd_back.
`timescale 1ns / 1ps

module websocket_frame_deframer_top #(
  parameter int QUEUE_DEPTH = wsd_pkg::QueueDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  wsd_in_if.sink    in_ch,
  wsd_out_if.source out_ch
);

  logic          accept;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  wsd_pkg::cmd_t cmd_in;
  wsd_pkg::cmd_t cmd_out;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  wsd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_ch.rx_byte),
    .push    (push),
    .cmd     (cmd_in)
  );

  wsd_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (pop),
    .dout  (cmd_out),
    .empty (empty)
  );

  wsd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .dout   (cmd_out),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
